### sv/btxq_pkg.sv
// Shared constants, codes and the node layout of the binary trie XOR query unit.
package btxq_pkg;

	localparam int KEY_BITS   = 21;
	localparam int NODE_COUNT = 4096;
	localparam int COUNT_BITS = 20;

	localparam int ADDR_BITS  = $clog2(NODE_COUNT);
	localparam int FREE_BITS  = ADDR_BITS + 1;
	localparam int LEVEL_BITS = $clog2(KEY_BITS);
	localparam int NODE_W     = 2 * ADDR_BITS + 2 * COUNT_BITS;

	localparam int CMD_BITS    = 3;
	localparam int STATUS_BITS = 2;
	localparam int IN_W        = CMD_BITS + KEY_BITS;
	localparam int OUT_W       = STATUS_BITS + 1 + KEY_BITS;
	localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	localparam logic [CMD_BITS-1:0] CMD_INSERT = 3'd0;
	localparam logic [CMD_BITS-1:0] CMD_ERASE  = 3'd1;
	localparam logic [CMD_BITS-1:0] CMD_FIND   = 3'd2;
	localparam logic [CMD_BITS-1:0] CMD_MIN    = 3'd3;
	localparam logic [CMD_BITS-1:0] CMD_MAX    = 3'd4;

	localparam logic [STATUS_BITS-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_BITS-1:0] STAT_NOTFOUND = 2'd1;
	localparam logic [STATUS_BITS-1:0] STAT_FULL     = 2'd2;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	typedef struct packed {
		logic [COUNT_BITS-1:0] cnt1;
		logic [COUNT_BITS-1:0] cnt0;
		logic [ADDR_BITS-1:0]  link1;
		logic [ADDR_BITS-1:0]  link0;
	} node_t;

endpackage

### sv/binary_trie_xor_query_unit.sv
// Binary trie multiset with insert, erase, find and minimum or maximum XOR queries.
//
// Commands enter on the s_ stream (command in the low bits of s_tdata, key above
// it) and one response per command leaves on the m_ stream (status, found flag,
// XOR result). The trie lives in a 4096-entry node memory with a registered read.
// A command walks the trie one level per cycle, most significant key bit first,
// reading a node and writing it back modified where the command changes counts.
// Erase walks twice (presence check, then decrement). A rejected insert, a
// query on an empty set and an undefined command answer without a walk. One
// command is in work at a time; the next command is taken once the current
// one has its response registered. The response register holds its transfer
// while m_tready is low; the unit can accept and work the next command meanwhile
// and waits only to hand over its response. Reset clears the counts, the node
// allocator and the root node; no memory clearing pass is needed, since every
// other node is written when it is allocated.
module binary_trie_xor_query_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// s_tdata fields from bit 0: command, key_value.
	input  logic [btxq_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// m_tdata fields from bit 0: status, found, xor_result.
	output logic [btxq_pkg::OUT_TDATA_W-1:0]  m_tdata
);
	import btxq_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_RESP = 2'd2;

	localparam logic [LEVEL_BITS-1:0] TOP_LEVEL = LEVEL_BITS'(KEY_BITS - 1);

	logic [NODE_W-1:0] mem [NODE_COUNT];
	logic [NODE_W-1:0] rd_q;

	logic [1:0]              state_q;
	logic [CMD_BITS-1:0]     cmd_q;
	logic [KEY_BITS-1:0]     key_q;
	logic [LEVEL_BITS-1:0]   level_q;
	logic [ADDR_BITS-1:0]    node_q;
	logic                    fresh_q;
	logic                    rd_blank_q;
	logic                    pass_q;
	logic                    root_valid_q;
	logic [KEY_BITS-1:0]     acc_q;
	logic [FREE_BITS-1:0]    next_free_q;
	logic [COUNT_BITS-1:0]   total_q;
	logic [STATUS_BITS-1:0]  res_status_q;
	logic                    res_found_q;
	logic [KEY_BITS-1:0]     res_xor_q;
	logic                    m_tvalid_q;
	logic [OUT_TDATA_W-1:0]  m_tdata_q;

	logic [CMD_BITS-1:0]  in_cmd;
	logic [KEY_BITS-1:0]  in_key;
	logic                 accept;
	logic                 store_full;
	logic                 need_walk;
	logic [STATUS_BITS-1:0] quick_status;

	node_t                 cur;
	node_t                 upd;
	logic                  bit_v;
	logic [ADDR_BITS-1:0]  link_v;
	logic [COUNT_BITS-1:0] cnt_v;
	logic                  edge_ok;
	logic                  pref;
	logic                  ok_p;
	logic                  ok_a;
	logic                  take;
	logic [ADDR_BITS-1:0]  new_link;
	logic                  alloc;
	logic                  last;
	logic                  walk_fail;
	logic                  walk_end;
	logic                  restart;
	logic [ADDR_BITS-1:0]  step_node;
	logic                  step_fresh;
	logic                  wr_en;
	logic [NODE_W-1:0]     wr_data;
	logic                  rd_en;
	logic [ADDR_BITS-1:0]  rd_addr;

	assign in_cmd   = s_tdata[CMD_BITS-1:0];
	assign in_key   = s_tdata[CMD_BITS +: KEY_BITS];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign store_full = (total_q == CNT_MAX) ||
		(next_free_q > FREE_BITS'(NODE_COUNT - KEY_BITS));

	always_comb begin
		need_walk    = 1'b0;
		quick_status = STAT_OK;
		case (in_cmd)
			CMD_INSERT: begin
				need_walk    = !store_full;
				quick_status = STAT_FULL;
			end
			CMD_ERASE, CMD_FIND: begin
				need_walk = 1'b1;
			end
			CMD_MIN, CMD_MAX: begin
				need_walk    = (total_q != '0);
				quick_status = STAT_NOTFOUND;
			end
			default: begin
				need_walk    = 1'b0;
				quick_status = STAT_OK;
			end
		endcase
	end

	always_comb begin
		cur      = (fresh_q || rd_blank_q) ? '0 : node_t'(rd_q);
		bit_v    = key_q[level_q];
		link_v   = bit_v ? cur.link1 : cur.link0;
		cnt_v    = bit_v ? cur.cnt1 : cur.cnt0;
		edge_ok  = (link_v != '0) && (cnt_v != '0);
		pref     = (cmd_q == CMD_MAX) ? ~bit_v : bit_v;
		ok_p     = pref ? ((cur.link1 != '0) && (cur.cnt1 != '0))
		                : ((cur.link0 != '0) && (cur.cnt0 != '0));
		ok_a     = pref ? ((cur.link0 != '0) && (cur.cnt0 != '0))
		                : ((cur.link1 != '0) && (cur.cnt1 != '0));
		take     = ok_p ? pref : ~pref;
		last     = (level_q == '0);
		upd      = cur;
		new_link = link_v;
		alloc    = 1'b0;
		walk_fail  = 1'b0;
		walk_end   = 1'b0;
		restart    = 1'b0;
		step_node  = link_v;
		step_fresh = fresh_q;
		wr_en      = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = '0;

		if (state_q == ST_WALK) begin
			case (cmd_q)
				CMD_INSERT: begin
					if (link_v == '0) begin
						alloc    = 1'b1;
						new_link = next_free_q[ADDR_BITS-1:0];
					end
					if (bit_v) begin
						upd.link1 = new_link;
						upd.cnt1  = cnt_v + 1'b1;
					end else begin
						upd.link0 = new_link;
						upd.cnt0  = cnt_v + 1'b1;
					end
					wr_en      = 1'b1;
					step_node  = new_link;
					step_fresh = fresh_q || alloc;
					walk_end   = last;
				end
				CMD_ERASE: begin
					if (pass_q) begin
						if (bit_v) begin
							upd.cnt1 = cnt_v - 1'b1;
						end else begin
							upd.cnt0 = cnt_v - 1'b1;
						end
						wr_en    = 1'b1;
						walk_end = last;
					end else if (!edge_ok) begin
						walk_fail = 1'b1;
					end else begin
						restart = last;
					end
				end
				CMD_FIND: begin
					walk_fail = !edge_ok;
					walk_end  = last;
				end
				CMD_MIN, CMD_MAX: begin
					walk_fail = !ok_p && !ok_a;
					step_node = take ? cur.link1 : cur.link0;
					walk_end  = last;
				end
				default: begin
					walk_end = 1'b1;
				end
			endcase
			if (restart) begin
				rd_en   = 1'b1;
				rd_addr = '0;
			end else begin
				rd_en   = !walk_fail && !walk_end && !step_fresh;
				rd_addr = step_node;
			end
		end else if (accept && need_walk) begin
			rd_en   = 1'b1;
			rd_addr = '0;
		end
	end

	assign wr_data = NODE_W'(upd);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[node_q] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= in_cmd;
			key_q <= in_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			level_q      <= '0;
			node_q       <= '0;
			fresh_q      <= 1'b0;
			rd_blank_q   <= 1'b0;
			pass_q       <= 1'b0;
			root_valid_q <= 1'b0;
			acc_q        <= '0;
			next_free_q  <= FREE_BITS'(1);
			total_q      <= '0;
			res_status_q <= STAT_OK;
			res_found_q  <= 1'b0;
			res_xor_q    <= '0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
		end else begin
			if (rd_en) begin
				rd_blank_q <= (rd_addr == '0) && !root_valid_q;
			end
			if (wr_en && (node_q == '0)) begin
				root_valid_q <= 1'b1;
			end
			if (alloc) begin
				next_free_q <= next_free_q + 1'b1;
			end
			if ((state_q == ST_RESP) && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						level_q      <= TOP_LEVEL;
						node_q       <= '0;
						fresh_q      <= 1'b0;
						pass_q       <= 1'b0;
						acc_q        <= '0;
						res_status_q <= quick_status;
						res_found_q  <= 1'b0;
						res_xor_q    <= '0;
						state_q      <= need_walk ? ST_WALK : ST_RESP;
					end
				end
				ST_WALK: begin
					if (!walk_fail && !walk_end && !restart) begin
						acc_q[level_q] <= take ^ bit_v;
					end
					if (walk_fail) begin
						res_status_q <= STAT_NOTFOUND;
						res_found_q  <= 1'b0;
						res_xor_q    <= '0;
						state_q      <= ST_RESP;
					end else if (restart) begin
						pass_q  <= 1'b1;
						level_q <= TOP_LEVEL;
						node_q  <= '0;
						fresh_q <= 1'b0;
					end else if (walk_end) begin
						res_status_q <= STAT_OK;
						res_found_q  <= (cmd_q == CMD_FIND);
						res_xor_q    <= ((cmd_q == CMD_MIN) || (cmd_q == CMD_MAX))
							? {acc_q[KEY_BITS-1:1], take ^ bit_v} : '0;
						if (cmd_q == CMD_INSERT) begin
							total_q <= total_q + 1'b1;
						end
						if (cmd_q == CMD_ERASE) begin
							total_q <= total_q - 1'b1;
						end
						state_q <= ST_RESP;
					end else begin
						level_q <= level_q - 1'b1;
						node_q  <= step_node;
						fresh_q <= step_fresh;
					end
				end
				ST_RESP: begin
					if (!m_tvalid_q || m_tready) begin
						m_tdata_q  <= OUT_TDATA_W'({res_xor_q, res_found_q, res_status_q});
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		next_free_q <= FREE_BITS'(NODE_COUNT))
		else $error("Node allocator ran past the end of the node memory.");

	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (FREE_BITS'(node_q) < next_free_q))
		else $error("Write to a node that was never allocated.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (level_q <= TOP_LEVEL))
		else $error("Trie walk level out of range.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_tdata_q[STATUS_BITS]) |-> (m_tdata_q[STATUS_BITS-1:0] == STAT_OK))
		else $error("Found flag raised on a response that is not ok.");

endmodule
